/* design/cpi_pkg.sv */
// Shared widths, constants and types for the circle pair intersection pipeline.
package cpi_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;

  localparam int CW   = COORD_BITS;      // coordinate width
  localparam int RW   = CW - 1;          // radius width
  localparam int DXW  = CW + 1;          // centre difference / sum width
  localparam int SQW  = 2 * CW;          // square of a difference or radius sum
  localparam int D2W  = 2 * CW + 1;      // squared centre distance
  localparam int KW   = 2 * CW - 1;      // r1^2 - r2^2
  localparam int MW   = 2 * CW + 2;      // radicand factors, signed
  localparam int MAGW = 2 * CW + 1;      // radicand factor magnitudes
  localparam int RADW = 2 * MAGW;        // radicand
  localparam int SGW  = MAGW;            // square root
  localparam int PW   = SGW + DXW;       // root times a centre difference
  localparam int NW   = 3 * CW + 5;      // numerators
  localparam int DENW = D2W + 1;         // divisor 2*d2
  localparam int REMW = 3 * CW + 2;      // divider remainder

  // split points for the wide multiplies
  localparam int D2L  = (D2W + 1) / 2;
  localparam int KL   = KW / 2;
  localparam int MAGL = (MAGW + 1) / 2;
  localparam int SGL  = (SGW + 1) / 2;

  // squared distance at or below this counts as coincident centres
  localparam logic [D2W-1:0] SAME_THR =
    D2W'((64'd1 << (2 * FRAC_BITS)) / 64'd10000000);

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic                  pick;
    logic                  same;
    logic                  nomeet;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic [D2W-1:0]        d2;
    logic signed [NW-1:0]  sub2;
    logic signed [NW-1:0]  sub3;
  } side_t;

  typedef struct packed {
    logic same;
    logic nomeet;
    logic hix;
    logic lox;
    logic hiy;
    logic loy;
  } flag_t;

endpackage

/* design/circle_pair_intersection.sv */
// Top level of the circle pair intersection pipeline with its output register.
//
// Takes one transaction per cycle unless a stall holds it, and passes each through
// seven front stages (differences, squares, radicand), one stage per root bit of
// the 49-bit square root, five stages of root selection and rounding, one stage
// per quotient bit of the 24-bit divider for x and y, and the output register. The
// whole pipeline holds while a finished result waits on out_ready, and moves
// again as soon as it is taken; nothing is dropped or repeated across a stall.
// centers_same and no_meet each force the point to zero; the point saturates to
// the signed coordinate range.
module circle_pair_intersection import cpi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_center1_x,
  input  logic signed [CW-1:0] in_center1_y,
  input  logic [RW-1:0]        in_radius1,
  input  logic signed [CW-1:0] in_center2_x,
  input  logic signed [CW-1:0] in_center2_y,
  input  logic [RW-1:0]        in_radius2,
  input  logic                 in_pick_upper,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] out_meet_x,
  output logic signed [CW-1:0] out_meet_y,
  output logic                 out_centers_same,
  output logic                 out_no_meet
);

  logic            en;
  logic            rad_valid, sig_valid, div_valid;
  logic [RADW-1:0] rad;
  logic [SGW-1:0]  sig;
  side_t           rad_side, sig_side;
  logic [CW-1:0]   div_qx, div_qy;
  flag_t           div_flag;

  logic                 out_valid_r;
  logic signed [CW-1:0] meet_x_r, meet_y_r, meet_x_nxt, meet_y_nxt;
  logic                 same_r, nomeet_r;

  // advance everything unless a held result is still waiting
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  cpi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .c1x       (in_center1_x),
    .c1y       (in_center1_y),
    .r1        (in_radius1),
    .c2x       (in_center2_x),
    .c2y       (in_center2_y),
    .r2        (in_radius2),
    .pick      (in_pick_upper),
    .rad_valid (rad_valid),
    .rad       (rad),
    .rad_side  (rad_side)
  );

  cpi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .rad_valid (rad_valid),
    .rad       (rad),
    .rad_side  (rad_side),
    .sig_valid (sig_valid),
    .sig       (sig),
    .sig_side  (sig_side)
  );

  cpi_solve u_solve (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .sig_valid (sig_valid),
    .sig       (sig),
    .sig_side  (sig_side),
    .q_valid   (div_valid),
    .qx        (div_qx),
    .qy        (div_qy),
    .q_flag    (div_flag)
  );

  always_comb begin
    if (div_flag.same || div_flag.nomeet) begin
      meet_x_nxt = '0;
      meet_y_nxt = '0;
    end else begin
      // quotients carry an offset of half the range: flip the top bit back
      if (div_flag.hix) begin
        meet_x_nxt = COORD_MAX;
      end else if (div_flag.lox) begin
        meet_x_nxt = COORD_MIN;
      end else begin
        meet_x_nxt = $signed({~div_qx[CW-1], div_qx[CW-2:0]});
      end
      if (div_flag.hiy) begin
        meet_y_nxt = COORD_MAX;
      end else if (div_flag.loy) begin
        meet_y_nxt = COORD_MIN;
      end else begin
        meet_y_nxt = $signed({~div_qy[CW-1], div_qy[CW-2:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meet_x_r <= meet_x_nxt;
      meet_y_r <= meet_y_nxt;
      same_r   <= div_flag.same;
      nomeet_r <= div_flag.nomeet && !div_flag.same;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_meet_x       = meet_x_r;
  assign out_meet_y       = meet_y_r;
  assign out_centers_same = same_r;
  assign out_no_meet      = nomeet_r;

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_centers_same && out_no_meet))
    else $error("centers_same and no_meet both set");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_centers_same || out_no_meet) |-> out_meet_x == '0 && out_meet_y == '0)
    else $error("flagged result carries a nonzero point");

  a_sat_excl: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid |-> !(div_flag.hix && div_flag.lox) && !(div_flag.hiy && div_flag.loy))
    else $error("quotient saturates both ways");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(div_valid) && $stable(div_qx) && $stable(div_qy))
    else $error("pipeline moved during a stall");

endmodule

/* design/cpi_front.sv */
// Front stages: differences, squares, radicand and the root-independent numerator parts.
module cpi_front import cpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [CW-1:0]  c1x,
  input  logic signed [CW-1:0]  c1y,
  input  logic [RW-1:0]         r1,
  input  logic signed [CW-1:0]  c2x,
  input  logic signed [CW-1:0]  c2y,
  input  logic [RW-1:0]         r2,
  input  logic                  pick,
  output logic                  rad_valid,
  output logic [RADW-1:0]       rad,
  output side_t                 rad_side
);

  logic [6:0] v_r;

  // stage 1
  logic signed [DXW-1:0] s1_dx_r, s1_dy_r, s1_sx_r, s1_sy_r;
  logic [CW-1:0]         s1_s_r;
  logic signed [CW-1:0]  s1_df_r;
  logic [RW-1:0]         s1_r1_r, s1_r2_r;
  logic                  s1_pick_r;

  // stage 2
  logic signed [2*DXW-1:0] pdx, pdy;
  logic [SQW-1:0]          pss;
  logic signed [2*CW-1:0]  pdf;
  logic [2*RW-1:0]         pr1, pr2;
  logic [SQW-1:0]          s2_dxsq_r, s2_dysq_r, s2_ssq_r, s2_dfsq_r;
  logic [2*RW-1:0]         s2_r1sq_r, s2_r2sq_r;
  logic signed [DXW-1:0]   s2_dx_r, s2_dy_r, s2_sx_r, s2_sy_r;
  logic                    s2_pick_r;

  // stage 3
  logic [D2W-1:0]        s3_d2_r;
  logic signed [KW-1:0]  s3_k_r;
  logic [SQW-1:0]        s3_ssq_r, s3_dfsq_r;
  logic signed [DXW-1:0] s3_dx_r, s3_dy_r, s3_sx_r, s3_sy_r;
  logic                  s3_pick_r;

  // stage 4
  logic signed [DXW+D2L:0]         pxl, pyl;
  logic signed [DXW+D2W-D2L:0]     pxh, pyh;
  logic signed [DXW+KL:0]          pkxl, pkyl;
  logic signed [DXW+KW-KL-1:0]     pkxh, pkyh;
  logic signed [DXW+D2L:0]         s4_pxl_r, s4_pyl_r;
  logic signed [DXW+D2W-D2L:0]     s4_pxh_r, s4_pyh_r;
  logic signed [DXW+KL:0]          s4_pkxl_r, s4_pkyl_r;
  logic signed [DXW+KW-KL-1:0]     s4_pkxh_r, s4_pkyh_r;
  logic signed [MW-1:0]            s4_a_r, s4_b_r;
  logic                            s4_same_r;
  logic [D2W-1:0]                  s4_d2_r;
  logic signed [DXW-1:0]           s4_dx_r, s4_dy_r;
  logic                            s4_pick_r;

  // stage 5
  logic [MAGW-1:0] s5_amag_r, s5_bmag_r;
  side_t           s5_side_nxt, s5_side_r;

  // stage 6
  logic [2*MAGL-1:0]          pll;
  logic [MAGW-1:0]            plh, phl;
  logic [2*(MAGW-MAGL)-1:0]   phh;
  logic [2*MAGL-1:0]          s6_ll_r;
  logic [MAGW-1:0]            s6_lh_r, s6_hl_r;
  logic [2*(MAGW-MAGL)-1:0]   s6_hh_r;
  side_t                      s6_side_r;

  // stage 7
  logic [RADW-1:0] s7_rad_r;
  side_t           s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  assign pdx = s1_dx_r * s1_dx_r;
  assign pdy = s1_dy_r * s1_dy_r;
  assign pss = s1_s_r * s1_s_r;
  assign pdf = s1_df_r * s1_df_r;
  assign pr1 = s1_r1_r * s1_r1_r;
  assign pr2 = s1_r2_r * s1_r2_r;

  assign pxl  = s3_sx_r * $signed({1'b0, s3_d2_r[D2L-1:0]});
  assign pxh  = s3_sx_r * $signed({1'b0, s3_d2_r[D2W-1:D2L]});
  assign pyl  = s3_sy_r * $signed({1'b0, s3_d2_r[D2L-1:0]});
  assign pyh  = s3_sy_r * $signed({1'b0, s3_d2_r[D2W-1:D2L]});
  assign pkxl = s3_dx_r * $signed({1'b0, s3_k_r[KL-1:0]});
  assign pkxh = s3_dx_r * $signed(s3_k_r[KW-1:KL]);
  assign pkyl = s3_dy_r * $signed({1'b0, s3_k_r[KL-1:0]});
  assign pkyh = s3_dy_r * $signed(s3_k_r[KW-1:KL]);

  always_comb begin
    s5_side_nxt.pick   = s4_pick_r;
    s5_side_nxt.same   = s4_same_r;
    // one factor negative and neither zero: the circles do not meet
    s5_side_nxt.nomeet = (s4_a_r[MW-1] != s4_b_r[MW-1]) && (s4_a_r != '0) && (s4_b_r != '0);
    s5_side_nxt.dx     = s4_dx_r;
    s5_side_nxt.dy     = s4_dy_r;
    s5_side_nxt.d2     = s4_d2_r;
    s5_side_nxt.sub2   = (NW'(s4_pxh_r) <<< D2L) + NW'(s4_pxl_r)
                       + (NW'(s4_pkxh_r) <<< KL) + NW'(s4_pkxl_r);
    s5_side_nxt.sub3   = (NW'(s4_pyh_r) <<< D2L) + NW'(s4_pyl_r)
                       + (NW'(s4_pkyh_r) <<< KL) + NW'(s4_pkyl_r);
  end

  assign pll = s5_amag_r[MAGL-1:0] * s5_bmag_r[MAGL-1:0];
  assign plh = s5_amag_r[MAGL-1:0] * s5_bmag_r[MAGW-1:MAGL];
  assign phl = s5_amag_r[MAGW-1:MAGL] * s5_bmag_r[MAGL-1:0];
  assign phh = s5_amag_r[MAGW-1:MAGL] * s5_bmag_r[MAGW-1:MAGL];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r   <= $signed({c2x[CW-1], c2x}) - $signed({c1x[CW-1], c1x});
      s1_dy_r   <= $signed({c2y[CW-1], c2y}) - $signed({c1y[CW-1], c1y});
      s1_sx_r   <= $signed({c1x[CW-1], c1x}) + $signed({c2x[CW-1], c2x});
      s1_sy_r   <= $signed({c1y[CW-1], c1y}) + $signed({c2y[CW-1], c2y});
      s1_s_r    <= {1'b0, r1} + {1'b0, r2};
      s1_df_r   <= $signed({1'b0, r1}) - $signed({1'b0, r2});
      s1_r1_r   <= r1;
      s1_r2_r   <= r2;
      s1_pick_r <= pick;

      s2_dxsq_r <= pdx[SQW-1:0];
      s2_dysq_r <= pdy[SQW-1:0];
      s2_ssq_r  <= pss;
      s2_dfsq_r <= pdf[SQW-1:0];
      s2_r1sq_r <= pr1;
      s2_r2sq_r <= pr2;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_sx_r   <= s1_sx_r;
      s2_sy_r   <= s1_sy_r;
      s2_pick_r <= s1_pick_r;

      s3_d2_r   <= D2W'(s2_dxsq_r) + D2W'(s2_dysq_r);
      s3_k_r    <= $signed({1'b0, s2_r1sq_r}) - $signed({1'b0, s2_r2sq_r});
      s3_ssq_r  <= s2_ssq_r;
      s3_dfsq_r <= s2_dfsq_r;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
      s3_pick_r <= s2_pick_r;

      s4_a_r    <= $signed(MW'(s3_ssq_r)) - $signed(MW'(s3_d2_r));
      s4_b_r    <= $signed(MW'(s3_d2_r)) - $signed(MW'(s3_dfsq_r));
      s4_same_r <= s3_d2_r <= SAME_THR;
      s4_pxl_r  <= pxl;
      s4_pxh_r  <= pxh;
      s4_pyl_r  <= pyl;
      s4_pyh_r  <= pyh;
      s4_pkxl_r <= pkxl;
      s4_pkxh_r <= pkxh;
      s4_pkyl_r <= pkyl;
      s4_pkyh_r <= pkyh;
      s4_d2_r   <= s3_d2_r;
      s4_dx_r   <= s3_dx_r;
      s4_dy_r   <= s3_dy_r;
      s4_pick_r <= s3_pick_r;

      s5_amag_r <= s4_a_r[MW-1] ? MAGW'(-s4_a_r) : MAGW'(s4_a_r);
      s5_bmag_r <= s4_b_r[MW-1] ? MAGW'(-s4_b_r) : MAGW'(s4_b_r);
      s5_side_r <= s5_side_nxt;

      s6_ll_r   <= pll;
      s6_lh_r   <= plh;
      s6_hl_r   <= phl;
      s6_hh_r   <= phh;
      s6_side_r <= s5_side_r;

      s7_rad_r  <= (RADW'(s6_hh_r) << (2 * MAGL)) + (RADW'(s6_lh_r) << MAGL)
                 + (RADW'(s6_hl_r) << MAGL) + RADW'(s6_ll_r);
      s7_side_r <= s6_side_r;
    end
  end

  assign rad_valid = v_r[6];
  assign rad       = s7_rad_r;
  assign rad_side  = s7_side_r;

endmodule

/* design/cpi_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
module cpi_sqrt import cpi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            rad_valid,
  input  logic [RADW-1:0] rad,
  input  side_t           rad_side,
  output logic            sig_valid,
  output logic [SGW-1:0]  sig,
  output side_t           sig_side
);

  logic [SGW-1:0]  v_r;
  logic [RADW-1:0] rem_r  [SGW];
  logic [SGW-1:0]  root_r [SGW];
  side_t           side_r [SGW];

  genvar j;
  for (j = 0; j < SGW; j++) begin : g_stage
    localparam int B = SGW - 1 - j;
    logic [RADW-1:0] rem_in, trial;
    logic [SGW-1:0]  root_in;
    side_t           s_in;
    logic            v_in, fits;

    if (j == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
      assign s_in    = rad_side;
      assign v_in    = rad_valid;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign s_in    = side_r[j-1];
      assign v_in    = v_r[j-1];
    end

    // (root + 2^B)^2 - root^2 against what is left of the radicand
    assign trial = (RADW'(root_in) << (B + 1)) | (RADW'(1) << (2 * B));
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= fits ? rem_in - trial : rem_in;
        root_r[j] <= root_in | (SGW'(fits) << B);
        side_r[j] <= s_in;
      end
    end
  end

  assign sig_valid = v_r[SGW-1];
  assign sig       = root_r[SGW-1];
  assign sig_side  = side_r[SGW-1];

endmodule

/* design/cpi_solve.sv */
// Root selection, rounding offset, range check and pipelined restoring division.
module cpi_solve import cpi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           sig_valid,
  input  logic [SGW-1:0] sig,
  input  side_t          sig_side,
  output logic           q_valid,
  output logic [CW-1:0]  qx,
  output logic [CW-1:0]  qy,
  output flag_t          q_flag
);

  logic [4:0] pv_r;

  // P1: root times the centre differences, split
  logic signed [DXW+SGL:0]     pyl, pxl;
  logic signed [DXW+SGW-SGL:0] pyh, pxh;
  logic signed [DXW+SGL:0]     p1_yl_r, p1_xl_r;
  logic signed [DXW+SGW-SGL:0] p1_yh_r, p1_xh_r;
  side_t                       p1_side_r;

  // P2
  logic signed [PW-1:0] p2_sdy_r, p2_sdx_r;
  side_t                p2_side_r;

  // P3
  logic                 take_first;
  logic signed [NW-1:0] p3_xn_r, p3_yn_r;
  logic [D2W-1:0]       p3_d2_r;
  logic                 p3_same_r, p3_nomeet_r;

  // P4
  logic signed [NW-1:0] p4_tx_r, p4_ty_r, p4_bnd_r;
  logic [DENW-1:0]      p4_den_r;
  logic                 p4_same_r, p4_nomeet_r;

  // P5
  logic [REMW-1:0] p5_tpx_r, p5_tpy_r;
  logic [DENW-1:0] p5_den_r;
  flag_t           p5_flag_nxt, p5_flag_r;

  // divider stages
  logic [CW-1:0]   dv_r;
  logic [REMW-1:0] remx_r [CW];
  logic [REMW-1:0] remy_r [CW];
  logic [CW-1:0]   qx_r   [CW];
  logic [CW-1:0]   qy_r   [CW];
  logic [DENW-1:0] den_r  [CW];
  flag_t           flag_r [CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[3:0], sig_valid};
    end
  end

  assign pyl = sig_side.dy * $signed({1'b0, sig[SGL-1:0]});
  assign pyh = sig_side.dy * $signed({1'b0, sig[SGW-1:SGL]});
  assign pxl = sig_side.dx * $signed({1'b0, sig[SGL-1:0]});
  assign pxh = sig_side.dx * $signed({1'b0, sig[SGW-1:SGL]});

  // first root is higher iff sig*dx < 0; on a tie an upper pick takes the second
  assign take_first = (p2_side_r.pick == p2_sdx_r[PW-1]);

  always_comb begin
    p5_flag_nxt.same   = p4_same_r;
    p5_flag_nxt.nomeet = p4_nomeet_r;
    p5_flag_nxt.hix    = p4_tx_r >= p4_bnd_r;
    p5_flag_nxt.lox    = p4_tx_r < -p4_bnd_r;
    p5_flag_nxt.hiy    = p4_ty_r >= p4_bnd_r;
    p5_flag_nxt.loy    = p4_ty_r < -p4_bnd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_yl_r   <= pyl;
      p1_yh_r   <= pyh;
      p1_xl_r   <= pxl;
      p1_xh_r   <= pxh;
      p1_side_r <= sig_side;

      p2_sdy_r  <= (PW'(p1_yh_r) <<< SGL) + PW'(p1_yl_r);
      p2_sdx_r  <= (PW'(p1_xh_r) <<< SGL) + PW'(p1_xl_r);
      p2_side_r <= p1_side_r;

      p3_xn_r     <= take_first ? p2_side_r.sub2 + NW'(p2_sdy_r)
                                : p2_side_r.sub2 - NW'(p2_sdy_r);
      p3_yn_r     <= take_first ? p2_side_r.sub3 - NW'(p2_sdx_r)
                                : p2_side_r.sub3 + NW'(p2_sdx_r);
      p3_d2_r     <= p2_side_r.d2;
      p3_same_r   <= p2_side_r.same;
      p3_nomeet_r <= p2_side_r.nomeet;

      // add half the divisor for round-half-up, scale the range bound
      p4_tx_r     <= p3_xn_r + $signed(NW'(p3_d2_r));
      p4_ty_r     <= p3_yn_r + $signed(NW'(p3_d2_r));
      p4_bnd_r    <= $signed(NW'(p3_d2_r) << CW);
      p4_den_r    <= DENW'(p3_d2_r) << 1;
      p4_same_r   <= p3_same_r;
      p4_nomeet_r <= p3_nomeet_r;

      // offset so an in-range quotient becomes unsigned
      p5_tpx_r  <= REMW'(p4_tx_r + p4_bnd_r);
      p5_tpy_r  <= REMW'(p4_ty_r + p4_bnd_r);
      p5_den_r  <= p4_den_r;
      p5_flag_r <= p5_flag_nxt;
    end
  end

  genvar j;
  for (j = 0; j < CW; j++) begin : g_div
    localparam int B = CW - 1 - j;
    logic [REMW-1:0] rx_in, ry_in, dsh;
    logic [CW-1:0]   qx_in, qy_in;
    logic [DENW-1:0] d_in;
    flag_t           f_in;
    logic            v_in, fx, fy;

    if (j == 0) begin : g_first
      assign rx_in = p5_tpx_r;
      assign ry_in = p5_tpy_r;
      assign qx_in = '0;
      assign qy_in = '0;
      assign d_in  = p5_den_r;
      assign f_in  = p5_flag_r;
      assign v_in  = pv_r[4];
    end else begin : g_next
      assign rx_in = remx_r[j-1];
      assign ry_in = remy_r[j-1];
      assign qx_in = qx_r[j-1];
      assign qy_in = qy_r[j-1];
      assign d_in  = den_r[j-1];
      assign f_in  = flag_r[j-1];
      assign v_in  = dv_r[j-1];
    end

    assign dsh = REMW'(d_in) << B;
    assign fx  = rx_in >= dsh;
    assign fy  = ry_in >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[j] <= fx ? rx_in - dsh : rx_in;
        remy_r[j] <= fy ? ry_in - dsh : ry_in;
        qx_r[j]   <= qx_in | (CW'(fx) << B);
        qy_r[j]   <= qy_in | (CW'(fy) << B);
        den_r[j]  <= d_in;
        flag_r[j] <= f_in;
      end
    end
  end

  assign q_valid = dv_r[CW-1];
  assign qx      = qx_r[CW-1];
  assign qy      = qy_r[CW-1];
  assign q_flag  = flag_r[CW-1];

endmodule
